/* src/wat_pkg.sv */
// Shared types, codes and helper functions of the weekly event alarm table.
package wat_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int NUM_LIGHTS = 32;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    localparam logic [8:0]  LIGHT_LIMIT = 9'(NUM_LIGHTS);
    localparam logic [10:0] MINUTE_MAX  = 11'd1439;

    localparam logic [2:0] MODE_ON     = 3'd0;
    localparam logic [2:0] MODE_OFF    = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_RANDOM = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    localparam logic [3:0] DAY_SUN  = 4'd0;
    localparam logic [3:0] DAY_MON  = 4'd1;
    localparam logic [3:0] DAY_FRI  = 4'd5;
    localparam logic [3:0] DAY_SAT  = 4'd6;
    localparam logic [3:0] DAY_ALL  = 4'd7;
    localparam logic [3:0] DAY_WORK = 4'd8;
    localparam logic [3:0] DAY_REST = 4'd9;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ON     = 2'd1;
    localparam logic [1:0] KIND_OFF    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_ID    = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic        is_off;
        logic [10:0] minute;
        logic [3:0]  day;
        logic [7:0]  light;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [7:0] light;
        logic       last;
    } result_t;

    function automatic logic day_match(logic [3:0] code, logic [3:0] today);
        logic hit;
        hit = (code == DAY_ALL) || (code == today) ||
              ((code == DAY_REST) && ((today == DAY_SUN) || (today == DAY_SAT))) ||
              ((code == DAY_WORK) && (today >= DAY_MON) && (today <= DAY_FRI));
        return hit;
    endfunction

    function automatic logic [10:0] sat_minute(logic [10:0] m, logic signed [6:0] off);
        logic signed [12:0] sum;
        logic [10:0]        res;
        sum = $signed({2'b00, m}) + $signed({{6{off[6]}}, off});
        if (sum < 13'sd0) begin
            res = 11'd0;
        end else if (sum > $signed({2'b00, MINUTE_MAX})) begin
            res = MINUTE_MAX;
        end else begin
            res = sum[10:0];
        end
        return res;
    endfunction

endpackage

/* src/wat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module wat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/weekly_event_alarm_table.sv */
// Weekly on/off alarm table for lights: schedule, remove, randomize and minute tick.
//
// Input channel s_*: one transfer carries a request; s_tuser holds the mode and
// s_tdata the light id, day code, minute and signed offset. Output channel m_*:
// each result transfer carries the result kind in m_tuser, status and light id in
// m_tdata, and m_tlast marks the final result of a request.
// A request is taken only while the block is idle. Requests that need the table
// walk it one slot per cycle (one read per cycle, registered read data) through
// the entry RAM, except while a tick walk holds; a rejected id or undefined mode
// skips the walk, and a stalling receiver holds a request until it takes the result.
// Schedule, remove and randomize stop at the first slot that qualifies; a tick
// walks every slot and gives one on/off command per due entry, or a single
// no-action result when nothing is due.
// The output is registered, so a finished result may wait on m_tready while the
// next request is taken. While a tick has a due entry ready and the output is
// still occupied, the walk holds in place until the receiver takes a transfer.
// After aresetn every slot is free; entry contents are undefined until written
// and are only read behind a set valid bit.
module weekly_event_alarm_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // light_id[7:0], day_code[11:8], minute[22:12],
                                   // random_offset[29:23], zero[31:30]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], out_light_id[9:2], zero[15:10]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int SW = wat_pkg::SLOT_W;
    localparam int CW = wat_pkg::CNT_W;
    localparam int NS = wat_pkg::NUM_SLOTS;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]        op_mode_reg, op_mode_next;
    logic [7:0]        op_light_reg, op_light_next;
    logic [3:0]        op_day_reg, op_day_next;
    logic [10:0]       op_min_reg, op_min_next;
    logic signed [6:0] op_off_reg, op_off_next;

    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          chk_act_reg, chk_act_next;
    logic [SW-1:0] chk_idx_reg, chk_idx_next;
    logic [NS-1:0] valid_reg, valid_next;

    logic       pend_vld_reg, pend_vld_next;
    logic [7:0] pend_light_reg, pend_light_next;
    logic       pend_off_reg, pend_off_next;

    wat_pkg::result_t fin_reg, fin_next;
    wat_pkg::result_t out_reg, out_next;
    logic             out_vld_reg, out_vld_next;

    logic                         ram_we;
    logic [SW-1:0]                ram_raddr;
    logic [wat_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [wat_pkg::ENTRY_W-1:0]  ram_rdata;
    wat_pkg::entry_t              ent;
    wat_pkg::entry_t              wr_ent;

    logic s_accept, out_free, cur_vld;
    logic is_sched, is_find, is_tick;
    logic hit_free, hit_find, hit_tick, stall, scan_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    assign ent     = wat_pkg::entry_t'(ram_rdata);
    assign cur_vld = valid_reg[chk_idx_reg];

    assign is_sched = (op_mode_reg == wat_pkg::MODE_ON) || (op_mode_reg == wat_pkg::MODE_OFF);
    assign is_find  = (op_mode_reg == wat_pkg::MODE_REMOVE) ||
                      (op_mode_reg == wat_pkg::MODE_RANDOM);
    assign is_tick  = (op_mode_reg == wat_pkg::MODE_TICK);

    assign hit_free = chk_act_reg && !cur_vld;
    assign hit_find = chk_act_reg && cur_vld && (ent.light == op_light_reg) &&
                      (ent.day == op_day_reg) && (ent.minute == op_min_reg);
    assign hit_tick = chk_act_reg && cur_vld && wat_pkg::day_match(ent.day, op_day_reg) &&
                      (ent.minute == op_min_reg);

    // hold the walk while a second due entry cannot be handed on
    assign stall     = (state_reg == ST_SCAN) && is_tick && hit_tick && pend_vld_reg &&
                       !out_free;
    assign scan_done = !chk_act_reg && (rd_idx_reg == CW'(NS));

    // re-read the checked slot during a hold so its data stays on the RAM output
    assign ram_raddr = stall ? chk_idx_reg : rd_idx_reg[SW-1:0];
    assign ram_wdata = wr_ent;

    wat_ram #(
        .WIDTH (wat_pkg::ENTRY_W),
        .DEPTH (NS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (chk_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        op_mode_next    = op_mode_reg;
        op_light_next   = op_light_reg;
        op_day_next     = op_day_reg;
        op_min_next     = op_min_reg;
        op_off_next     = op_off_reg;
        rd_idx_next     = rd_idx_reg;
        chk_act_next    = chk_act_reg;
        chk_idx_next    = chk_idx_reg;
        valid_next      = valid_reg;
        pend_vld_next   = pend_vld_reg;
        pend_light_next = pend_light_reg;
        pend_off_next   = pend_off_reg;
        fin_next        = fin_reg;
        out_next        = out_reg;
        out_vld_next    = out_vld_reg;
        ram_we          = 1'b0;
        wr_ent          = ent;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_mode_next  = s_tuser;
                    op_light_next = s_tdata[7:0];
                    op_day_next   = s_tdata[11:8];
                    op_min_next   = s_tdata[22:12];
                    op_off_next   = $signed(s_tdata[29:23]);
                    rd_idx_next   = '0;
                    chk_act_next  = 1'b0;
                    pend_vld_next = 1'b0;
                    if (((s_tuser == wat_pkg::MODE_ON) || (s_tuser == wat_pkg::MODE_OFF)) &&
                        ({1'b0, s_tdata[7:0]} >= wat_pkg::LIGHT_LIMIT)) begin
                        fin_next   = '{wat_pkg::KIND_STATUS, wat_pkg::STS_BAD_ID, 8'd0, 1'b1};
                        state_next = ST_FINISH;
                    end else if (s_tuser <= wat_pkg::MODE_TICK) begin
                        state_next = ST_SCAN;
                    end else begin
                        fin_next   = '{wat_pkg::KIND_NONE, wat_pkg::STS_OK, 8'd0, 1'b1};
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    // advance the read side
                    if (rd_idx_reg < CW'(NS)) begin
                        chk_act_next = 1'b1;
                        chk_idx_next = rd_idx_reg[SW-1:0];
                        rd_idx_next  = rd_idx_reg + CW'(1);
                    end else begin
                        chk_act_next = 1'b0;
                    end

                    if (is_sched && hit_free) begin
                        ram_we          = 1'b1;
                        wr_ent.is_off   = (op_mode_reg == wat_pkg::MODE_OFF);
                        wr_ent.minute   = op_min_reg;
                        wr_ent.day      = op_day_reg;
                        wr_ent.light    = op_light_reg;
                        valid_next[chk_idx_reg] = 1'b1;
                        fin_next     = '{wat_pkg::KIND_STATUS, wat_pkg::STS_OK, 8'd0, 1'b1};
                        chk_act_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else if (is_find && hit_find) begin
                        if (op_mode_reg == wat_pkg::MODE_REMOVE) begin
                            valid_next[chk_idx_reg] = 1'b0;
                        end else begin
                            ram_we        = 1'b1;
                            wr_ent.minute = wat_pkg::sat_minute(ent.minute, op_off_reg);
                        end
                        fin_next     = '{wat_pkg::KIND_STATUS, wat_pkg::STS_OK, 8'd0, 1'b1};
                        chk_act_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else if (is_tick && hit_tick) begin
                        // hand the previous due entry on, keep this one back for tlast
                        if (pend_vld_reg) begin
                            out_vld_next = 1'b1;
                            out_next     = '{pend_off_reg ? wat_pkg::KIND_OFF : wat_pkg::KIND_ON,
                                             wat_pkg::STS_OK, pend_light_reg, 1'b0};
                        end
                        pend_vld_next   = 1'b1;
                        pend_light_next = ent.light;
                        pend_off_next   = ent.is_off;
                    end else if (scan_done) begin
                        fin_next   = '{wat_pkg::KIND_STATUS,
                                       is_sched ? wat_pkg::STS_FULL : wat_pkg::STS_NOT_FOUND,
                                       8'd0, 1'b1};
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_vld_next = 1'b1;
                    if (is_tick) begin
                        if (pend_vld_reg) begin
                            out_next = '{pend_off_reg ? wat_pkg::KIND_OFF : wat_pkg::KIND_ON,
                                         wat_pkg::STS_OK, pend_light_reg, 1'b1};
                        end else begin
                            out_next = '{wat_pkg::KIND_NONE, wat_pkg::STS_OK, 8'd0, 1'b1};
                        end
                    end else begin
                        out_next = fin_reg;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chk_act_reg  <= 1'b0;
            rd_idx_reg   <= '0;
            valid_reg    <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chk_act_reg  <= chk_act_next;
            rd_idx_reg   <= rd_idx_next;
            valid_reg    <= valid_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
        op_mode_reg    <= op_mode_next;
        op_light_reg   <= op_light_next;
        op_day_reg     <= op_day_next;
        op_min_reg     <= op_min_next;
        op_off_reg     <= op_off_next;
        chk_idx_reg    <= chk_idx_next;
        pend_light_reg <= pend_light_next;
        pend_off_reg   <= pend_off_next;
        fin_reg        <= fin_next;
        out_reg        <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg.light, out_reg.status};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule
